// ----- sv/fpdct_pkg.sv -----
// constants, types and the cosine table of the dct-ii cepstrum unit
// the table is built at elaboration with q60 integer arithmetic (taylor series)
// no dependencies
`default_nettype none

package fpdct_pkg;

    localparam int MEL_BANDS     = 26;
    localparam int CEP_COUNT     = 13;
    localparam int COEFF_FRAC    = 15;

    localparam int DATA_W        = 32;
    localparam int ENERGY_FRAC_W = 5;
    localparam int FACTOR_W      = 31;
    localparam int FILTERS_W     = 5;
    localparam int INDEX_W       = 4;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;

    localparam int COEF_W  = COEFF_FRAC + 2;
    localparam int PERIOD  = 4 * MEL_BANDS;
    localparam int M_W     = $clog2(PERIOD);
    localparam int ACC_W   = DATA_W + COEFF_FRAC;
    localparam int PROD_W  = DATA_W + COEF_W;
    localparam int TERM_W  = PROD_W - COEFF_FRAC;
    localparam int ADDR_W  = (MEL_BANDS > 1) ? $clog2(MEL_BANDS) : 1;
    localparam int FILL_W  = $clog2(MEL_BANDS + 1);
    localparam int K_W     = $clog2(CEP_COUNT + 1);

    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60     = 64'h1 << 60;
    localparam logic [63:0] ROUND_BIAS  = 64'h1 << 20;
    localparam logic [63:0] HALF_PERIOD = 64'(2 * MEL_BANDS);
    localparam int          TAYLOR_TERMS = 20;

    typedef logic [63:0] taylor_div_t [TAYLOR_TERMS];

    // (2i-1)*(2i) for the cosine series
    localparam taylor_div_t TAYLOR_DIVISOR = '{
        64'd2,   64'd12,  64'd30,  64'd56,  64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380,
        64'd462, 64'd552, 64'd650, 64'd756, 64'd870,
        64'd992, 64'd1122, 64'd1260, 64'd1406, 64'd1560
    };

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t cos_table_t [PERIOD];

    typedef enum logic [1:0] {
        REG_ENERGY_FRAC = 2'd0,
        REG_FACTOR_DC   = 2'd1,
        REG_FACTOR_AC   = 2'd2,
        REG_FILTERS     = 2'd3
    } reg_index_t;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // cos(pi*j/(2*MEL_BANDS)) in q60
    function automatic logic [63:0] cos_q60(input logic [63:0] j);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (PI_Q60 / HALF_PERIOD) * j + ((PI_Q60 % HALF_PERIOD) * j) / HALF_PERIOD;
        x2   = mul_q60(x, x);
        term = ONE_Q60;
        sum  = signed'(ONE_Q60);
        for (int i = 1; i <= TAYLOR_TERMS; i++)
        begin
            term = mul_q60(term, x2) / TAYLOR_DIVISOR[i-1];
            if ((i & 1) == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = '0;
        return unsigned'(sum);
    endfunction

    // cos(pi*m/(2*MEL_BANDS)) truncated to COEFF_FRAC fraction bits
    function automatic coef_t cos_entry(input int m);
        int          q;
        int          r;
        int          j;
        logic        neg;
        logic [63:0] mag;
        q   = m / MEL_BANDS;
        r   = m % MEL_BANDS;
        j   = ((q & 1) == 1) ? (MEL_BANDS - r) : r;
        neg = (q == 1) || (q == 2);
        if (j == MEL_BANDS)
            mag = '0;
        else if (j == 0)
            mag = 64'h1 << COEFF_FRAC;
        else
            mag = (cos_q60(64'(j)) + ROUND_BIAS) >> (60 - COEFF_FRAC);
        return neg ? coef_t'(-COEF_W'(mag)) : coef_t'(mag);
    endfunction

    function automatic cos_table_t build_cos_table();
        cos_table_t t;
        for (int m = 0; m < PERIOD; m++)
        begin
            t[m] = cos_entry(m);
        end
        return t;
    endfunction

    localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

`default_nettype wire

// ----- sv/fixed_point_dct_ii_cepstrum_unit.sv -----
// fixed-point dct-ii cepstrum unit: energy store, shared mac, scaling and output register
// depends on fpdct_pkg
//
// usage: one signed mel energy per input beat (in_valid / in_stall / energy). energies
// are written to a 26-entry synchronous store. the beat that completes a frame of
// filters_in_use energies starts the transform; the unit then sends 13 output beats
// (coefficient, coeff_index, last_coeff) with last_coeff high on index 12.
// a beat that does not close a frame only writes the store. after the closing beat each
// coefficient is formed by the single multiply-accumulate, which reads one stored energy
// per cycle for filters_in_use energies (count clamped to 1 .. 26), then the mac pipeline
// drains and the scaling multiply is registered before the output register is loaded.
// in_stall is high while the transform runs. the result sits in an output register,
// so a stall on the output only holds the unit once the next result is ready.
// reset clears the fill count, the control state and the registers (energy_frac_bits
// 15, factor_dc 6426, factor_ac 9088, filters_in_use 26); the store is not cleared.
// configuration is written over the apb port, registers at byte address 4*i.
`default_nettype none

module fixed_point_dct_ii_cepstrum_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [fpdct_pkg::DATA_W-1:0]   energy,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [fpdct_pkg::DATA_W-1:0]        coefficient,
    output logic [fpdct_pkg::INDEX_W-1:0]              coeff_index,
    output logic                                       last_coeff,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [fpdct_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [fpdct_pkg::PDATA_W-1:0]         pwdata,
    output logic [fpdct_pkg::PDATA_W-1:0]              prdata,
    output logic                                       pready
);

    import fpdct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_SCALE1,
        S_SCALE2
    } state_t;

    state_t                      state_reg, state_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [K_W-1:0]              k_reg, k_next;
    logic [M_W-1:0]              kbase_reg, kbase_next;
    logic [M_W-1:0]              step_reg, step_next;
    logic [ADDR_W-1:0]           n_reg, n_next;
    logic [M_W-1:0]              m_reg, m_next;
    logic                        v1_reg, v2_reg, v3_reg;
    logic                        out_valid_reg, out_valid_next;

    logic [ENERGY_FRAC_W-1:0]    energy_frac_bits_reg;
    logic [FACTOR_W-1:0]         factor_dc_reg;
    logic [FACTOR_W-1:0]         factor_ac_reg;
    logic [FILTERS_W-1:0]        filters_in_use_reg;

    logic signed [DATA_W-1:0]    mem [MEL_BANDS];
    logic signed [DATA_W-1:0]    rd_data_reg;
    coef_t                       c1_reg, c2_reg;
    logic signed [DATA_W-1:0]    e_al_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic [DATA_W+FACTOR_W-1:0]  p_lo_reg;
    logic [COEFF_FRAC-1:0]       p_hi_reg;
    logic signed [DATA_W-1:0]    coefficient_reg;
    logic [INDEX_W-1:0]          coeff_index_reg;
    logic                        last_coeff_reg;

    logic                        in_accept;
    logic                        cfg_write;
    logic [FILL_W-1:0]           eff;
    logic [FILL_W-1:0]           eff_last;
    logic [FILL_W-1:0]           fill_inc;
    logic                        frame_done;
    logic                        issue_last;
    logic                        out_free;
    logic                        k_last;
    logic                        load_out;
    logic                        acc_clear;
    logic                        pipe_busy;
    logic [M_W:0]                m_sum;
    logic [M_W-1:0]              m_step;
    logic [M_W:0]                s_sum;
    logic [M_W-1:0]              step_inc;
    logic [M_W-1:0]              kbase_inc;
    logic signed [DATA_W-1:0]    e_al;
    logic [ENERGY_FRAC_W-1:0]    shl_amt;
    logic [ENERGY_FRAC_W-1:0]    shr_amt;
    logic signed [TERM_W-1:0]    term;
    logic [FACTOR_W-1:0]         factor_sel;
    logic [ACC_W-1:0]            scaled;

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_index_t'(paddr[PADDR_W-1:2]))
            REG_ENERGY_FRAC: prdata = PDATA_W'(energy_frac_bits_reg);
            REG_FACTOR_DC:   prdata = PDATA_W'(factor_dc_reg);
            REG_FACTOR_AC:   prdata = PDATA_W'(factor_ac_reg);
            REG_FILTERS:     prdata = PDATA_W'(filters_in_use_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_frac_bits_reg <= ENERGY_FRAC_W'(15);
            factor_dc_reg        <= FACTOR_W'(6426);
            factor_ac_reg        <= FACTOR_W'(9088);
            filters_in_use_reg   <= FILTERS_W'(26);
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[PADDR_W-1:2]))
                REG_ENERGY_FRAC: energy_frac_bits_reg <= pwdata[ENERGY_FRAC_W-1:0];
                REG_FACTOR_DC:   factor_dc_reg        <= pwdata[FACTOR_W-1:0];
                REG_FACTOR_AC:   factor_ac_reg        <= pwdata[FACTOR_W-1:0];
                REG_FILTERS:     filters_in_use_reg   <= pwdata[FILTERS_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective filter count, clamped to 1 .. MEL_BANDS
    always_comb
    begin
        if (filters_in_use_reg == '0)
            eff = FILL_W'(1);
        else if (int'(filters_in_use_reg) > MEL_BANDS)
            eff = FILL_W'(MEL_BANDS);
        else
            eff = FILL_W'(filters_in_use_reg);
    end

    assign eff_last   = eff - 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign fill_inc   = fill_reg + 1'b1;
    assign frame_done = (fill_inc >= eff);
    assign issue_last = (FILL_W'(n_reg) == eff_last);
    assign out_free   = !out_valid_reg || !out_stall;
    assign k_last     = (k_reg == K_W'(CEP_COUNT - 1));
    assign load_out   = (state_reg == S_SCALE2) && out_free;
    assign pipe_busy  = v1_reg || v2_reg || v3_reg;
    assign acc_clear  = (in_accept && frame_done) || (load_out && !k_last);

    // cosine phase (2n+1)*k mod PERIOD, stepped by 2k per energy
    assign m_sum     = {1'b0, m_reg} + {1'b0, step_reg};
    assign m_step    = (m_sum >= (M_W+1)'(PERIOD)) ? M_W'(m_sum - (M_W+1)'(PERIOD))
                                                   : M_W'(m_sum);
    assign s_sum     = {1'b0, step_reg} + (M_W+1)'(2);
    assign step_inc  = (s_sum >= (M_W+1)'(PERIOD)) ? M_W'(s_sum - (M_W+1)'(PERIOD))
                                                   : M_W'(s_sum);
    assign kbase_inc = (kbase_reg == M_W'(PERIOD - 1)) ? '0 : kbase_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        kbase_next     = kbase_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (frame_done)
                    begin
                        fill_next  = '0;
                        k_next     = '0;
                        kbase_next = '0;
                        step_next  = '0;
                        n_next     = '0;
                        m_next     = '0;
                        state_next = S_MAC;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            S_MAC:
            begin
                n_next = n_reg + 1'b1;
                m_next = m_step;
                if (issue_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = S_SCALE1;
            end
            S_SCALE1:
            begin
                state_next = S_SCALE2;
            end
            S_SCALE2:
            begin
                if (out_free)
                begin
                    if (k_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        kbase_next = kbase_inc;
                        step_next  = step_inc;
                        n_next     = '0;
                        m_next     = kbase_inc;
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            k_reg           <= '0;
            kbase_reg       <= '0;
            step_reg        <= '0;
            n_reg           <= '0;
            m_reg           <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            coefficient_reg <= '0;
            coeff_index_reg <= '0;
            last_coeff_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            kbase_reg     <= kbase_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            m_reg         <= m_next;
            v1_reg        <= (state_reg == S_MAC);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                coefficient_reg <= scaled[ACC_W-1:COEFF_FRAC];
                coeff_index_reg <= INDEX_W'(k_reg);
                last_coeff_reg  <= k_last;
            end
        end
    end

    // energy store
    always_ff @(posedge clk)
    begin
        if (in_accept)
            mem[fill_reg[ADDR_W-1:0]] <= energy;
        rd_data_reg <= mem[n_reg];
    end

    // align to COEFF_FRAC fraction bits
    assign shl_amt = ENERGY_FRAC_W'(COEFF_FRAC) - energy_frac_bits_reg;
    assign shr_amt = energy_frac_bits_reg - ENERGY_FRAC_W'(COEFF_FRAC);

    always_comb
    begin
        if (energy_frac_bits_reg < ENERGY_FRAC_W'(COEFF_FRAC))
            e_al = rd_data_reg <<< shl_amt;
        else
            e_al = rd_data_reg >>> shr_amt;
    end

    assign term       = prod_reg[PROD_W-1:COEFF_FRAC];
    assign factor_sel = (k_reg == '0) ? factor_dc_reg : factor_ac_reg;
    assign scaled     = p_lo_reg[ACC_W-1:0] + {p_hi_reg, DATA_W'(0)};

    always_ff @(posedge clk)
    begin
        c1_reg   <= COS_TABLE[m_reg];
        c2_reg   <= c1_reg;
        e_al_reg <= e_al;
        prod_reg <= PROD_W'(e_al_reg) * PROD_W'(c2_reg);
        if (acc_clear)
            acc_reg <= '0;
        else if (v3_reg)
            acc_reg <= acc_reg + ACC_W'(term);
        if (state_reg == S_SCALE1)
        begin
            p_lo_reg <= (DATA_W+FACTOR_W)'(acc_reg[DATA_W-1:0])
                      * (DATA_W+FACTOR_W)'(factor_sel);
            p_hi_reg <= COEFF_FRAC'(acc_reg[ACC_W-1:DATA_W] * factor_sel[COEFF_FRAC-1:0]);
        end
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coefficient_reg;
    assign coeff_index = coeff_index_reg;
    assign last_coeff  = last_coeff_reg;

    // a closing energy starts coefficient zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && frame_done) |=> (state_reg == S_MAC && k_reg == '0 && fill_reg == '0))
        else $error("closing beat did not start the transform");

    // mac pipeline only runs inside the accumulation phase
    assert property (@(posedge clk) disable iff (!rst_n)
        pipe_busy |-> (state_reg == S_MAC || state_reg == S_DRAIN))
        else $error("mac pipeline active outside accumulation");

    // scaling starts only on a drained accumulator
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCALE1) |-> ($past(state_reg) == S_DRAIN && !pipe_busy))
        else $error("scaling started before the accumulator drained");

endmodule

`default_nettype wire

// ----- bench/tb_fixed_point_dct_ii_cepstrum_unit.sv -----
// self-checking bench for the fixed-point dct-ii cepstrum unit: directed frames, then random
// traffic with register changes between phases; expected coefficients from an in-bench model
// depends on fpdct_pkg and fixed_point_dct_ii_cepstrum_unit
`timescale 1ns / 1ps

module tb_fixed_point_dct_ii_cepstrum_unit;

    import fpdct_pkg::*;

    localparam logic [63:0] PI_Q60_REF = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_TURN  = 64'(2 * MEL_BANDS);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [INDEX_W-1:0]       index;
        logic                     last;
    } cep_beat_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [DATA_W-1:0]    energy;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DATA_W-1:0]    coefficient;
    logic [INDEX_W-1:0]          coeff_index;
    logic                        last_coeff;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [PDATA_W-1:0]          pwdata;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;

    int                          dct_rom [CEP_COUNT][MEL_BANDS];
    logic [DATA_W-1:0]           frame_energy [MEL_BANDS];
    int                          frame_fill = 0;
    logic [ENERGY_FRAC_W-1:0]    frac_bits = 15;
    logic [FACTOR_W-1:0]         dc_scale = 6426;
    logic [FACTOR_W-1:0]         ac_scale = 9088;
    logic [FILTERS_W-1:0]        filter_count = 26;
    cep_beat_t                   pending_ceps [$];

    int                          src_idle_pct = 13;
    int                          sink_idle_pct = 67;
    int                          beats_sent = 0;
    int                          frames_done = 0;
    int                          ceps_checked = 0;
    int                          cfg_writes = 0;
    int                          phase_no = 0;
    int                          mismatches = 0;

    fixed_point_dct_ii_cepstrum_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .energy      (energy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coefficient (coefficient),
        .coeff_index (coeff_index),
        .last_coeff  (last_coeff),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cos(pi*j/(2*MEL_BANDS)) in q60 by taylor series
    function automatic logic [63:0] quarter_wave_q60(input int j);
        logic [127:0]       wide;
        logic [63:0]        ang;
        logic [63:0]        sq;
        logic [63:0]        term;
        logic signed [63:0] total;
        ang   = (PI_Q60_REF / HALF_TURN) * 64'(j)
              + ((PI_Q60_REF % HALF_TURN) * 64'(j)) / HALF_TURN;
        wide  = {64'd0, ang} * {64'd0, ang};
        sq    = wide[123:60];
        term  = 64'd1 << 60;
        total = signed'(term);
        for (int i = 1; i <= 20; i++)
        begin
            wide = {64'd0, term} * {64'd0, sq};
            term = wide[123:60] / 64'((2 * i - 1) * (2 * i));
            if (i % 2 == 1)
                total = total - signed'(term);
            else
                total = total + signed'(term);
        end
        if (total < 0)
            total = '0;
        return total;
    endfunction

    function automatic void build_dct_rom();
        int          m;
        int          q;
        int          r;
        int          j;
        logic [63:0] mag;
        for (int k = 0; k < CEP_COUNT; k++)
        begin
            for (int n = 0; n < MEL_BANDS; n++)
            begin
                m = ((2 * n + 1) * k) % (4 * MEL_BANDS);
                q = m / MEL_BANDS;
                r = m % MEL_BANDS;
                j = (q % 2 == 1) ? MEL_BANDS - r : r;
                if (j == MEL_BANDS)
                    mag = '0;
                else if (j == 0)
                    mag = 64'd1 << COEFF_FRAC;
                else
                    mag = (quarter_wave_q60(j) + (64'd1 << 20)) >> (60 - COEFF_FRAC);
                dct_rom[k][n] = (q == 1 || q == 2) ? -int'(mag) : int'(mag);
            end
        end
    endfunction

    // stores one energy; on frame close queues the coefficients it yields
    function automatic void absorb_energy(input logic [DATA_W-1:0] e);
        int                 eff;
        logic [DATA_W-1:0]  aligned;
        logic signed [63:0] wide_e;
        logic signed [63:0] wide_c;
        logic signed [63:0] acc;
        logic signed [63:0] scaled;
        cep_beat_t          beat;
        eff = (filter_count == 0) ? 1 :
              ((filter_count > MEL_BANDS) ? MEL_BANDS : int'(filter_count));
        if (frame_fill >= MEL_BANDS)
            frame_fill = 0;
        frame_energy[frame_fill] = e;
        frame_fill++;
        if (frame_fill < eff)
            return;
        frame_fill = 0;
        frames_done++;
        for (int k = 0; k < CEP_COUNT; k++)
        begin
            acc = '0;
            for (int n = 0; n < eff; n++)
            begin
                aligned = frame_energy[n];
                if (COEFF_FRAC > int'(frac_bits))
                    aligned = aligned << (COEFF_FRAC - int'(frac_bits));
                else if (COEFF_FRAC < int'(frac_bits))
                    aligned = signed'(aligned) >>> (int'(frac_bits) - COEFF_FRAC);
                wide_e = signed'(aligned);
                wide_c = dct_rom[k][n];
                acc    = acc + ((wide_e * wide_c) >>> COEFF_FRAC);
            end
            wide_c     = (k == 0) ? {33'd0, dc_scale} : {33'd0, ac_scale};
            scaled     = (acc * wide_c) >>> COEFF_FRAC;
            beat.value = scaled[DATA_W-1:0];
            beat.index = INDEX_W'(k);
            beat.last  = (k == CEP_COUNT - 1);
            pending_ceps.push_back(beat);
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_energy();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: v = 32'h7FFFFFFF;
                    1: v = 32'h80000000;
                    2: v = '0;
                    default: v = 32'hFFFFFFFF;
                endcase
            end
            1, 2, 3, 4: v = $urandom();
            default:
            begin
                v = $urandom_range(0, 32'h000FFFFF);
                if ($urandom_range(1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [PDATA_W-1:0] pick_factor();
        case ($urandom_range(7))
            0: return '0;
            1: return 32'h7FFFFFFF;
            2: return $urandom();
            default: return $urandom_range(2000, 20000);
        endcase
    endfunction

    // output beats are checked against the oldest expected coefficient
    always @(posedge clk)
    begin : check_outputs
        cep_beat_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_ceps.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got coefficient %0d index %0d",
                         $time, coefficient, coeff_index);
                mismatches++;
            end
            else
            begin
                want = pending_ceps.pop_front();
                ceps_checked++;
                if (coefficient !== want.value)
                begin
                    $display("%0t: coefficient index %0d expected %0d got %0d",
                             $time, want.index, $signed(want.value), coefficient);
                    mismatches++;
                end
                if (coeff_index !== want.index)
                begin
                    $display("%0t: coeff_index expected %0d got %0d",
                             $time, want.index, coeff_index);
                    mismatches++;
                end
                if (last_coeff !== want.last)
                begin
                    $display("%0t: last_coeff at index %0d expected %0b got %0b",
                             $time, want.index, want.last, last_coeff);
                    mismatches++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    task automatic send_energy(input logic [DATA_W-1:0] e);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        energy   <= e;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        absorb_energy(e);
        beats_sent++;
    endtask

    // hold the input until every queued coefficient is out, plus a short settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_ceps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENERGY_FRAC: frac_bits    = val[ENERGY_FRAC_W-1:0];
            REG_FACTOR_DC:   dc_scale     = val[FACTOR_W-1:0];
            REG_FACTOR_AC:   ac_scale     = val[FACTOR_W-1:0];
            REG_FILTERS:     filter_count = val[FILTERS_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [PDATA_W-1:0] frac, input logic [PDATA_W-1:0] dc,
                                input logic [PDATA_W-1:0] ac, input logic [PDATA_W-1:0] filt);
        write_reg(REG_ENERGY_FRAC, frac);
        write_reg(REG_FACTOR_DC, dc);
        write_reg(REG_FACTOR_AC, ac);
        write_reg(REG_FILTERS, filt);
    endtask

    task automatic apply_random_config();
        logic [PDATA_W-1:0] frac;
        logic [PDATA_W-1:0] filt;
        int                 sel;
        frac = ($urandom_range(3) == 0) ? 15 : $urandom_range(0, 31);
        sel  = $urandom_range(19);
        if (phase_no == 0)
            filt = 31;
        else if (sel < 11)
            filt = $urandom_range(1, 6);
        else if (sel < 14)
            filt = $urandom_range(7, 26);
        else if (sel < 16)
            filt = 0;
        else
            filt = $urandom_range(26, 31);
        apply_config(frac, pick_factor(), pick_factor(), filt);
    endtask

    // full frame under the reset register values, field extremes first
    task automatic test_reset_frame();
        wait_idle();
        send_energy(32'h7FFFFFFF);
        send_energy(32'h80000000);
        send_energy(32'h00000000);
        send_energy(32'h00000001);
        send_energy(32'hFFFFFFFF);
        send_energy(32'hAAAAAAAA);
        send_energy(32'h55555555);
        repeat (MEL_BANDS - 7) send_energy(pick_energy());
        wait_idle();
    endtask

    // shift extremes, zero and full-scale factors, zero filter count
    task automatic test_alignment_extremes();
        wait_idle();
        apply_config(0, 0, 32'h7FFFFFFF, 0);
        send_energy(32'h7FFFFFFF);
        send_energy(32'h80000000);
        wait_idle();
        write_reg(REG_ENERGY_FRAC, 30);
        send_energy(32'h80000000);
        wait_idle();
        write_reg(REG_ENERGY_FRAC, 31);
        write_reg(REG_FACTOR_DC, 32'h7FFFFFFF);
        write_reg(REG_FACTOR_AC, 0);
        send_energy(32'h7FFFFFFF);
        send_energy(32'hFFFFFFFF);
        wait_idle();
    endtask

    // filter count lowered and raised while a frame is partly filled
    task automatic test_filter_count_change();
        wait_idle();
        apply_config(15, 6426, 9088, 4);
        send_energy(pick_energy());
        send_energy(pick_energy());
        wait_idle();
        write_reg(REG_FILTERS, 2);
        send_energy(pick_energy());
        wait_idle();
        send_energy(pick_energy());
        wait_idle();
        write_reg(REG_FILTERS, 3);
        send_energy(pick_energy());
        send_energy(pick_energy());
        wait_idle();
    endtask

    task automatic test_random_traffic(input int items);
        int sent;
        int burst;
        sent = 0;
        while (sent < items)
        begin
            wait_idle();
            apply_random_config();
            burst = (phase_no == 0) ? 30 : $urandom_range(6, 40);
            if (burst > items - sent)
                burst = items - sent;
            phase_no++;
            repeat (burst)
            begin
                send_energy(pick_energy());
                sent++;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        energy    = '0;
        out_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        build_dct_rom();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_frame();
        test_alignment_extremes();
        test_filter_count_change();
        test_random_traffic(128);
        src_idle_pct  = 67;
        sink_idle_pct = 13;
        test_random_traffic(128);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(128);
        repeat (40) @(posedge clk);

        $display("covered %0d energy beats closing %0d frames, %0d coefficients checked",
                 beats_sent, frames_done, ceps_checked);
        $display("over %0d register writes and three input/output pacing modes", cfg_writes);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("%0t: timeout with %0d coefficients outstanding", $time, pending_ceps.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
